### hw/rtl/sdp_pkg.sv
// Shared types, constants and byte-classification functions for the SSE data parser.
package sdp_pkg;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [2:0] NAME_LEN = 3'd4;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_NAME  = 3'd1,
      PH_SKIP  = 3'd2,
      PH_VALUE = 3'd3
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] match_cnt;
      logic       have_data;
      logic       held_cr;
      logic       first_val;
   } parse_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       event_end;
   } res_type;

   typedef struct packed {
      parse_state_type st;
      res_type         res;
   } step_type;

   // One queue entry: all results caused by one request (one or two)
   typedef struct packed {
      logic       two;
      logic [7:0] data0;
      logic       end0;
      logic [7:0] data1;
      logic       end1;
   } q_entry_type;

   // Field name "data", one character per match position
   function automatic logic [7:0] name_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h64;  // d
         2'd1: c = 8'h61;  // a
         2'd2: c = 8'h74;  // t
         default: c = 8'h61;  // a
      endcase
      return c;
   endfunction

   // A data line begins: LF joins it to an earlier data line of the event
   function automatic step_type start_data_line(input parse_state_type s);
      step_type t;
      t     = '0;
      t.st  = s;
      if (s.have_data) begin
         t.res.valid = 1'b1;
         t.res.data  = CH_LF;
      end
      t.st.have_data = 1'b1;
      return t;
   endfunction

   // One byte of line content (never LF)
   function automatic step_type take_content(input parse_state_type s, input logic [7:0] b);
      step_type t;
      logic     done;
      logic     drop;
      t    = '0;
      t.st = s;
      done = 1'b0;
      drop = 1'b0;
      if (t.st.phase == PH_START) begin
         if (b == CH_COLON) begin
            t.st.phase = PH_SKIP;
            done       = 1'b1;
         end else begin
            t.st.phase     = PH_NAME;
            t.st.match_cnt = '0;
         end
      end
      if (!done) begin
         if (t.st.phase == PH_NAME) begin
            if (t.st.match_cnt < NAME_LEN && b == name_char(t.st.match_cnt[1:0])) begin
               t.st.match_cnt = t.st.match_cnt + 3'd1;
            end else if (t.st.match_cnt == NAME_LEN && b == CH_COLON) begin
               t              = start_data_line(t.st);
               t.st.first_val = 1'b1;
               t.st.phase     = PH_VALUE;
            end else begin
               t.st.phase = PH_SKIP;
            end
         end else if (t.st.phase == PH_VALUE) begin
            drop           = t.st.first_val && (b == CH_SPACE);
            t.st.first_val = 1'b0;
            if (!drop) begin
               t.res.valid = 1'b1;
               t.res.data  = b;
            end
         end
      end
      return t;
   endfunction

   // LF: close the line, maybe dispatch the event
   function automatic step_type end_line(input parse_state_type s);
      step_type t;
      t    = '0;
      t.st = s;
      if (s.phase == PH_START) begin
         if (s.have_data) begin
            t.res.valid     = 1'b1;
            t.res.event_end = 1'b1;
         end
         t.st.have_data = 1'b0;
      end else if (s.phase == PH_NAME && s.match_cnt == NAME_LEN) begin
         t = start_data_line(s);
      end
      t.st.phase     = PH_START;
      t.st.match_cnt = '0;
      t.st.first_val = 1'b0;
      return t;
   endfunction

endpackage

### hw/rtl/sdp_req_if.sv
// Request channel: one raw stream byte per request.
interface sdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

### hw/rtl/sdp_rsp_if.sv
// Result channel: data bytes and event-end markers.
interface sdp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       event_end;
   logic       last_of_item;

   modport source (output valid, output data_byte, output event_end, output last_of_item,
                   input ready);
   modport sink (input valid, input data_byte, input event_end, input last_of_item,
                 output ready);
endinterface

### hw/rtl/sdp_front.sv
// Front end: takes stream bytes, tracks line state, forms result entries.
module sdp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           byte_in,
   output logic                 byte_ready,
   input  logic                 q_full,
   output logic                 q_push,
   output sdp_pkg::q_entry_type q_entry
);
   import sdp_pkg::*;

   parse_state_type state_ff, state_in;
   step_type        stp0, stp1;
   res_type         res0, res1;
   logic            accept;

   assign byte_ready = !q_full;
   assign accept     = byte_valid && !q_full;

   // Held CR is resolved first, then the new byte
   always_comb begin
      stp0     = '0;
      stp1     = '0;
      res0     = '0;
      res1     = '0;
      state_in = state_ff;
      if (state_ff.held_cr) begin
         state_in.held_cr = 1'b0;
         if (byte_in == CH_LF) begin
            stp0 = end_line(state_in);
         end else begin
            stp0 = take_content(state_in, CH_CR);
         end
         state_in = stp0.st;
         res0     = stp0.res;
      end
      if (!(state_ff.held_cr && byte_in == CH_LF)) begin
         if (byte_in == CH_CR) begin
            state_in.held_cr = 1'b1;
         end else begin
            if (byte_in == CH_LF) begin
               stp1 = end_line(state_in);
            end else begin
               stp1 = take_content(state_in, byte_in);
            end
            state_in = stp1.st;
            res1     = stp1.res;
         end
      end
   end

   // Pack results to the front of the entry
   always_comb begin
      q_entry = '0;
      if (res0.valid) begin
         q_entry.data0 = res0.event_end ? 8'h00 : res0.data;
         q_entry.end0  = res0.event_end;
         q_entry.two   = res1.valid;
         q_entry.data1 = res1.event_end ? 8'h00 : res1.data;
         q_entry.end1  = res1.event_end;
      end else begin
         q_entry.data0 = res1.event_end ? 8'h00 : res1.data;
         q_entry.end0  = res1.event_end;
      end
      q_push = accept && (res0.valid || res1.valid);
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_START, match_cnt: 3'd0, have_data: 1'b0,
                       held_cr: 1'b0, first_val: 1'b0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/sdp_queue.sv
// Short FIFO of result entries between front and back.
module sdp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sdp_pkg::q_entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output sdp_pkg::q_entry_type pop_entry,
   output logic                 empty
);
   import sdp_pkg::*;

   q_entry_type         mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### hw/rtl/sdp_back.sv
// Back end: splits queue entries into single results on an output register.
module sdp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  sdp_pkg::q_entry_type q_entry,
   output logic                 q_pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_data,
   output logic                 out_end,
   output logic                 out_last
);
   import sdp_pkg::*;

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   logic [7:0] data_ff, data_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;
   logic       slot_free;

   assign slot_free = !valid_ff || out_ready;

   // Load next result when the output slot frees up
   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      data_in   = data_ff;
      end_in    = end_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      if (slot_free) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            if (!second_ff) begin
               data_in = q_entry.data0;
               end_in  = q_entry.end0;
               last_in = !q_entry.two;
               if (q_entry.two) begin
                  second_in = 1'b1;
               end else begin
                  q_pop = 1'b1;
               end
            end else begin
               data_in   = q_entry.data1;
               end_in    = q_entry.end1;
               last_in   = 1'b1;
               second_in = 1'b0;
               q_pop     = 1'b1;
            end
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_end   = end_ff;
   assign out_last  = last_ff;

endmodule

### hw/rtl/sse_data_event_parser.sv
// SSE data parser: takes stream bytes, emits data bytes and event ends.
// Throughput: one request per cycle while the result queue has room; a request that
//   gives two results occupies the output for one rsp transfer per result.
// Path: a result is written to the result queue, then loaded into the output register,
//   and only then is it valid on rsp; rsp.ready low holds it in the output register.
// Reset (synchronous): parser returns to line start with no event data, queue empties.
module sse_data_event_parser (
   input logic       clock,
   input logic       reset,
   sdp_req_if.sink   req,
   sdp_rsp_if.source rsp
);
   import sdp_pkg::*;

   q_entry_type push_entry;
   q_entry_type pop_entry;
   logic        q_push, q_full, q_pop, q_empty;

   sdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req.valid),
      .byte_in    (req.in_byte),
      .byte_ready (req.ready),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   sdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   sdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.data_byte),
      .out_end   (rsp.event_end),
      .out_last  (rsp.last_of_item)
   );

endmodule
